@@ rtl/yuv_to_v210_packer_unit_assert.svh @@
// assertion macros for the v210 packer checker
`ifndef YUV_TO_V210_PACKER_UNIT_ASSERT_SVH
`define YUV_TO_V210_PACKER_UNIT_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define YTV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("packer check failed");

// next-cycle implication, ignored while in reset
`define YTV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("packer check failed");

// next-cycle implication that also holds across reset
`define YTV_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("packer check failed");

`endif

@@ rtl/ytv_pkg.sv @@
`default_nettype none

package ytv_pkg;

  // fixed field and register widths
  localparam int CFG_W       = 14;
  localparam int WORD_W      = 30;
  localparam int SAMPLE_W    = 10;
  localparam int PAIR_CNT_W  = 12;
  localparam int WORD_CNT_W  = 13;
  localparam int ROW_CNT_W   = 13;
  localparam int PAD_CNT_W   = 5;

  // frame limits and register reset values
  localparam int MAX_WIDTH       = 8192;
  localparam int MAX_HEIGHT      = 8192;
  localparam int WIDTH_RESET     = 1920;
  localparam int HEIGHT_RESET    = 1080;
  localparam int ROW_ALIGN_BYTES = 128;
  localparam int ALIGN_WORDS     = ROW_ALIGN_BYTES / 4;
  localparam int ALIGN_GROUPS    = ALIGN_WORDS / 4;

  // divide by six via reciprocal, exact for values below 2**17
  localparam int DIV6_MUL   = 43691;
  localparam int DIV6_SHIFT = 18;

  // register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] cr;
    logic [7:0] cb;
    logic [7:0] y1;
    logic [7:0] y0;
  } pair_t;

  typedef logic [WORD_W-1:0] word_t;

  // 8-bit sample widened to 10 bits
  function automatic logic [SAMPLE_W-1:0] widen(input logic [7:0] s);
    return {s, 2'b00};
  endfunction

  function automatic word_t pack3(input logic [7:0] a, input logic [7:0] b,
                                  input logic [7:0] c);
    return {widen(c), widen(b), widen(a)};
  endfunction

  // clamp a register value into 1..limit
  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] limit);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_W'(1);
    else if (v > limit) r = limit;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/yuv_to_v210_packer_unit.sv @@
`default_nettype none

// v210 packer: each input transfer is one pixel pair (two 8-bit lumas and the
// Cb/Cr they share); every three pairs become four 30-bit v210 words, and the
// last group of a row is followed by zero words up to a 128-byte row boundary
// (at most 28). The first two pairs of a group are accepted even while earlier
// words are still being sent, unless one of them ends a row. The pair that
// closes a group is taken once the word emitter can load it (in the cycle its
// previous group's last word transfers at the earliest), so throughput is set
// by the single output word port, which sends a group's four words and then
// any padding words at a row end, and which out_stall can hold.
module yuv_to_v210_packer_unit
  import ytv_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_write_enable,
  input  wire                  cfg_index,
  input  wire [CFG_W-1:0]      cfg_data,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire [7:0]            in_luma_first,
  input  wire [7:0]            in_luma_second,
  input  wire [7:0]            in_chroma_blue,
  input  wire [7:0]            in_chroma_red,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [WORD_W-1:0]    out_packed_word,
  output logic                 out_row_end,
  output logic                 out_frame_end
);

  // configuration registers
  logic [CFG_W-1:0] frame_width_r, frame_height_r;

  // row and group tracking
  pair_t                 held_r [2];
  logic [1:0]            slot_r;
  logic [PAIR_CNT_W-1:0] pair_in_row_r;
  logic [WORD_CNT_W-1:0] words_in_row_r;
  logic [ROW_CNT_W-1:0]  row_index_r;

  // word emitter
  word_t                 buf_r [4];
  logic                  busy_r, pad_phase_r, row_last_r, frame_last_r;
  logic [1:0]            word_idx_r;
  logic [PAD_CNT_W-1:0]  pad_left_r;

  logic [CFG_W-1:0]      eff_w, eff_h;
  logic [CFG_W-1:0]      pairs;
  logic [CFG_W-1:0]      wplus;
  logic [29:0]           div_prod;
  logic [10:0]           groups;
  logic [WORD_CNT_W-1:0] total_words, words_nxt;
  logic [PAD_CNT_W-1:0]  pad;
  logic                  last, last_row, need_emit;
  logic                  in_xfer, out_xfer, final_word, emit_done, load;
  pair_t                 cur, fill, p0, p1, p2;

  // effective frame size and row geometry
  assign eff_w    = clamp_dim(frame_width_r, CFG_W'(MAX_WIDTH));
  assign eff_h    = clamp_dim(frame_height_r, CFG_W'(MAX_HEIGHT));
  assign pairs    = (eff_w + CFG_W'(1)) >> 1;
  assign last     = ({2'b00, pair_in_row_r} + CFG_W'(1)) >= pairs;
  assign last_row = ({1'b0, row_index_r} + CFG_W'(1)) >= eff_h;

  // padded row length in words: groups = ceil(w / 6)
  assign wplus       = eff_w + CFG_W'(5);
  assign div_prod    = {16'd0, wplus} * 30'(DIV6_MUL);
  assign groups      = div_prod[DIV6_SHIFT +: 11];
  assign total_words = WORD_CNT_W'(((32'(groups) + 32'(ALIGN_GROUPS - 1)) / ALIGN_GROUPS)
                                   * ALIGN_WORDS);
  assign words_nxt   = words_in_row_r + WORD_CNT_W'(4);
  assign pad         = (last && total_words > words_nxt) ?
                       PAD_CNT_W'(total_words - words_nxt) : '0;

  // current pair with odd-width fix and the edge fill pair
  always_comb begin
    cur.y0 = in_luma_first;
    cur.y1 = (last && eff_w[0]) ? in_luma_first : in_luma_second;
    cur.cb = in_chroma_blue;
    cur.cr = in_chroma_red;
    fill.y0 = cur.y1;
    fill.y1 = cur.y1;
    fill.cb = cur.cb;
    fill.cr = cur.cr;
  end

  // group pairs from held entries, the current pair and fill
  always_comb begin
    p0 = (slot_r == 2'd0) ? cur : held_r[0];
    p1 = (slot_r == 2'd1) ? cur : ((slot_r == 2'd0) ? fill : held_r[1]);
    p2 = (slot_r == 2'd2) ? cur : fill;
  end

  // handshake
  assign need_emit  = last || (slot_r == 2'd2);
  assign out_xfer   = busy_r && !out_stall;
  assign final_word = pad_phase_r ? (pad_left_r == PAD_CNT_W'(1)) :
                      (word_idx_r == 2'd3 && pad_left_r == '0);
  assign emit_done  = out_xfer && final_word;
  assign in_stall   = busy_r && !emit_done && need_emit;
  assign in_xfer    = in_valid && !in_stall;
  assign load       = in_xfer && need_emit;

  // output word and flags
  assign out_valid       = busy_r;
  assign out_packed_word = pad_phase_r ? '0 : buf_r[word_idx_r];
  assign out_row_end     = busy_r && final_word && row_last_r;
  assign out_frame_end   = out_row_end && frame_last_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= CFG_W'(WIDTH_RESET);
      frame_height_r <= CFG_W'(HEIGHT_RESET);
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // held pairs of the open group
  always_ff @(posedge clk) begin
    if (in_xfer && !need_emit) begin
      held_r[slot_r[0]] <= cur;
    end
  end

  // row and frame counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r         <= '0;
      pair_in_row_r  <= '0;
      words_in_row_r <= '0;
      row_index_r    <= '0;
    end else if (in_xfer) begin
      if (!need_emit) begin
        slot_r        <= slot_r + 2'd1;
        pair_in_row_r <= pair_in_row_r + PAIR_CNT_W'(1);
      end else begin
        slot_r <= '0;
        if (last) begin
          pair_in_row_r  <= '0;
          words_in_row_r <= '0;
          row_index_r    <= last_row ? '0 : row_index_r + ROW_CNT_W'(1);
        end else begin
          pair_in_row_r  <= pair_in_row_r + PAIR_CNT_W'(1);
          words_in_row_r <= words_nxt;
        end
      end
    end
  end

  // word buffer load
  always_ff @(posedge clk) begin
    if (load) begin
      buf_r[0] <= pack3(p0.cb, p0.y0, p0.cr);
      buf_r[1] <= pack3(p0.y1, p1.cb, p1.y0);
      buf_r[2] <= pack3(p1.cr, p1.y1, p2.cb);
      buf_r[3] <= pack3(p2.y0, p2.cr, p2.y1);
    end
  end

  // emitter sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      pad_phase_r  <= 1'b0;
      word_idx_r   <= '0;
      pad_left_r   <= '0;
      row_last_r   <= 1'b0;
      frame_last_r <= 1'b0;
    end else if (load) begin
      busy_r       <= 1'b1;
      pad_phase_r  <= 1'b0;
      word_idx_r   <= '0;
      pad_left_r   <= pad;
      row_last_r   <= last;
      frame_last_r <= last && last_row;
    end else if (emit_done) begin
      busy_r <= 1'b0;
    end else if (out_xfer) begin
      if (pad_phase_r) begin
        pad_left_r <= pad_left_r - PAD_CNT_W'(1);
      end else if (word_idx_r == 2'd3) begin
        pad_phase_r <= 1'b1;
      end else begin
        word_idx_r <= word_idx_r + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/ytv_checker.sv @@
`default_nettype none

`include "yuv_to_v210_packer_unit_assert.svh"

module ytv_checker
  import ytv_pkg::*;
(
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_stall,
  input wire                 out_valid,
  input wire                 out_stall,
  input wire [WORD_W-1:0]    out_packed_word,
  input wire                 out_row_end,
  input wire                 out_frame_end
);

  // frame end only on a row end word
  `YTV_ASSERT_NOW(a_frame_on_row, out_valid && out_frame_end, out_row_end)

  // with no words pending the input is never held off
  `YTV_ASSERT_NOW(a_no_idle_stall, !out_valid, !in_stall)

  // a stalled word stays put
  `YTV_ASSERT_NEXT(a_hold_word, out_valid && out_stall,
                   out_valid && $stable(out_packed_word) && $stable(out_row_end))

  // nothing to send right after reset
  `YTV_ASSERT_ALWAYS(a_reset_empty, !rst_n, !out_valid)

endmodule

bind yuv_to_v210_packer_unit ytv_checker u_ytv_checker (.*);

`default_nettype wire
